// ===== design/lavm_pkg.sv =====
// Shared types, constants and helpers for the look-at view matrix block.
`default_nettype none
package lavm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int Q_DEPTH   = 4;

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] up_hint_x;
    logic signed [31:0] up_hint_y;
    logic signed [31:0] up_hint_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] right_x;
    logic signed [31:0] right_y;
    logic signed [31:0] right_z;
    logic signed [31:0] right_offset;
    logic signed [31:0] true_up_x;
    logic signed [31:0] true_up_y;
    logic signed [31:0] true_up_z;
    logic signed [31:0] true_up_offset;
    logic signed [31:0] back_x;
    logic signed [31:0] back_y;
    logic signed [31:0] back_z;
    logic signed [31:0] back_offset;
  } out_t;

  typedef struct packed {
    logic [2:0][31:0] eye;
    logic [2:0][31:0] up;
    logic [2:0][32:0] d;
  } fwd_t;

  function automatic int norm_latency(input int frac);
    return 39 + frac;
  endfunction

  function automatic logic [5:0] lead_one(input logic [62:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 63; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== design/lavm_fifo.sv =====
// Small show-ahead register queue.
`default_nettype none
module lavm_fifo #(
  parameter type T = logic,
  parameter int DEPTH = lavm_pkg::Q_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr,
  input  wire T     wdata,
  output logic      full,
  input  wire logic rd,
  output T          rdata,
  output logic      empty
);
  localparam int AW = $clog2(DEPTH);

  T mem [DEPTH];
  logic [AW:0] wptr, rptr;

  assign empty = (wptr == rptr);
  assign full  = (wptr[AW-1:0] == rptr[AW-1:0]) && (wptr[AW] != rptr[AW]);
  assign rdata = mem[rptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
    end else begin
      if (wr && !full) wptr <= wptr + 1'b1;
      if (rd && !empty) rptr <= rptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr && !full) mem[wptr[AW-1:0]] <= wdata;
  end
endmodule
`default_nettype wire

// ===== design/lavm_front.sv =====
// Front stage: takes a pose request and forms eye minus target.
`default_nettype none
module lavm_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire lavm_pkg::in_t pose,
  output logic               q_push,
  input  wire logic          q_full,
  output lavm_pkg::fwd_t     q_data
);
  logic vld;
  logic take;

  assign full   = vld && q_full;
  assign take   = push && !full;
  assign q_push = vld && !q_full;

  always_ff @(posedge clk) begin
    if (rst) vld <= 1'b0;
    else     vld <= take || (vld && q_full);
  end

  always_ff @(posedge clk) begin
    if (take) begin
      q_data.eye  <= {pose.eye_x, pose.eye_y, pose.eye_z};
      q_data.up   <= {pose.up_hint_x, pose.up_hint_y, pose.up_hint_z};
      q_data.d[2] <= 33'({pose.eye_x[31], pose.eye_x} - {pose.target_x[31], pose.target_x});
      q_data.d[1] <= 33'({pose.eye_y[31], pose.eye_y} - {pose.target_y[31], pose.target_y});
      q_data.d[0] <= 33'({pose.eye_z[31], pose.eye_z} - {pose.target_z[31], pose.target_z});
    end
  end
endmodule
`default_nettype wire

// ===== design/lavm_norm.sv =====
// Pipelined vector normalizer: block scaling, square root and three dividers.
`default_nettype none
module lavm_norm #(
  parameter int FRAC = lavm_pkg::FRAC_BITS,
  parameter type SIDE_T = logic
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [2:0][63:0]  v_in,
  input  wire SIDE_T             side_in,
  output logic [2:0][31:0]       u_out,
  output SIDE_T                  side_out
);
  localparam int LAT = lavm_pkg::norm_latency(FRAC);
  localparam int NW  = 31 + FRAC;

  typedef struct packed {
    logic [2:0][29:0] m;
    logic [2:0]       s;
    logic             z;
  } mg_t;

  typedef struct packed {
    logic [2:0][NW-1:0] num;
    logic [2:0][30:0]   rem;
    logic [2:0][FRAC:0] q;
    logic [30:0]        dvs;
    logic [2:0]         s;
    logic               z;
  } dv_t;

  SIDE_T side_q [LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= side_in;
      for (int k = 1; k < LAT; k++) side_q[k] <= side_q[k-1];
    end
  end
  assign side_out = side_q[LAT-1];

  logic [2:0][62:0] mag_c;
  logic [62:0]      big_c;
  logic [2:0][62:0] m1;
  logic [2:0]       s1;
  logic [62:0]      big1;

  always_comb begin
    logic [63:0] ng;
    for (int i = 0; i < 3; i++) begin
      ng = -v_in[i];
      mag_c[i] = v_in[i][63] ? ng[62:0] : v_in[i][62:0];
    end
    big_c = mag_c[0];
    if (mag_c[1] > big_c) big_c = mag_c[1];
    if (mag_c[2] > big_c) big_c = mag_c[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1   <= mag_c;
      big1 <= big_c;
      for (int i = 0; i < 3; i++) s1[i] <= v_in[i][63];
    end
  end

  logic [2:0][62:0] m2;
  logic [2:0]       s2;
  logic [5:0]       pos2;
  logic             z2;

  always_ff @(posedge clk) begin
    if (en) begin
      m2   <= m1;
      s2   <= s1;
      pos2 <= lavm_pkg::lead_one(big1);
      z2   <= (big1 == '0);
    end
  end

  mg_t st3;
  always_ff @(posedge clk) begin
    logic [62:0] t;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (pos2 >= 6'd30) t = m2[i] >> (pos2 - 6'd29);
        else               t = m2[i] << (6'd29 - pos2);
        st3.m[i] <= t[29:0];
      end
      st3.s <= s2;
      st3.z <= z2;
    end
  end

  mg_t st4;
  logic [2:0][59:0] sq4;
  always_ff @(posedge clk) begin
    if (en) begin
      st4 <= st3;
      for (int i = 0; i < 3; i++) sq4[i] <= 60'(st3.m[i]) * 60'(st3.m[i]);
    end
  end

  logic [61:0] sx [32];
  logic [61:0] sr [32];
  mg_t         mg [32];

  always_ff @(posedge clk) begin
    if (en) begin
      sx[0] <= 62'(sq4[0]) + 62'(sq4[1]) + 62'(sq4[2]);
      sr[0] <= '0;
      mg[0] <= st4;
    end
  end

  for (genvar k = 0; k < 31; k++) begin : g_sqrt
    localparam logic [61:0] BIT = 62'd1 << (60 - 2 * k);
    logic [61:0] t;
    logic        ge;
    assign t  = sr[k] + BIT;
    assign ge = (sx[k] >= t);
    always_ff @(posedge clk) begin
      if (en) begin
        sx[k+1] <= ge ? sx[k] - t : sx[k];
        sr[k+1] <= ge ? (sr[k] >> 1) + BIT : sr[k] >> 1;
        mg[k+1] <= mg[k];
      end
    end
  end

  dv_t dv [FRAC+2];

  always_ff @(posedge clk) begin
    logic [NW-1:0] n;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n = {mg[31].m[i], {(FRAC+1){1'b0}}} >> 1;
        n = n + NW'(sr[31][30:1]);
        dv[0].num[i] <= n;
        dv[0].rem[i] <= 31'(n >> (FRAC + 1));
        dv[0].q[i]   <= '0;
      end
      dv[0].dvs <= sr[31][30:0];
      dv[0].s   <= mg[31].s;
      dv[0].z   <= mg[31].z;
    end
  end

  for (genvar j = 0; j <= FRAC; j++) begin : g_div
    always_ff @(posedge clk) begin
      dv_t         nx;
      logic [31:0] t;
      if (en) begin
        nx = dv[j];
        for (int i = 0; i < 3; i++) begin
          t = {dv[j].rem[i], dv[j].num[i][FRAC-j]};
          if (t >= {1'b0, dv[j].dvs}) begin
            t = t - {1'b0, dv[j].dvs};
            nx.q[i][FRAC-j] = 1'b1;
          end
          nx.rem[i] = t[30:0];
        end
        dv[j+1] <= nx;
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [31:0] q;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        q = 32'(dv[FRAC+1].q[i]);
        if (dv[FRAC+1].z)      u_out[i] <= '0;
        else if (dv[FRAC+1].s[i]) u_out[i] <= -q;
        else                   u_out[i] <= q;
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/lavm_back.sv =====
// Back pipeline: three normalizers, two cross products and the offset dots.
`default_nettype none
module lavm_back #(
  parameter int FRAC = lavm_pkg::FRAC_BITS
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_empty,
  input  wire lavm_pkg::fwd_t  q_data,
  output logic                 q_pop,
  output logic                 o_push,
  input  wire logic            o_full,
  output lavm_pkg::out_t       o_data
);
  localparam int LAT = lavm_pkg::norm_latency(FRAC);
  localparam int TOT = 3 * LAT + 6;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC - 1);

  typedef struct packed {
    logic [2:0][31:0] eye;
    logic [2:0][31:0] up;
  } sd1_t;

  typedef struct packed {
    logic [2:0][31:0] eye;
    logic [2:0][31:0] bk;
  } sd2_t;

  typedef struct packed {
    logic [2:0][31:0] eye;
    logic [2:0][31:0] bk;
    logic [2:0][31:0] rt;
  } sd3_t;

  logic en;
  logic [TOT-1:0] vld;

  assign en     = !(vld[TOT-1] && o_full);
  assign q_pop  = en && !q_empty;
  assign o_push = en && vld[TOT-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[TOT-2:0], !q_empty};
  end

  logic [2:0][63:0] v1;
  sd1_t             si1, so1;
  logic [2:0][31:0] bk1;

  always_comb begin
    for (int i = 0; i < 3; i++) v1[i] = 64'($signed(q_data.d[i]));
    si1.eye = q_data.eye;
    si1.up  = q_data.up;
  end

  lavm_norm #(.FRAC(FRAC), .SIDE_T(sd1_t)) u_norm_back (
    .clk(clk), .en(en), .v_in(v1), .side_in(si1), .u_out(bk1), .side_out(so1)
  );

  logic signed [63:0] pa [6];
  sd2_t c1s, c2s;
  logic [2:0][63:0] v2;

  always_ff @(posedge clk) begin
    if (en) begin
      pa[0] <= $signed(so1.up[1]) * $signed(bk1[0]);
      pa[1] <= $signed(so1.up[0]) * $signed(bk1[1]);
      pa[2] <= $signed(so1.up[0]) * $signed(bk1[2]);
      pa[3] <= $signed(so1.up[2]) * $signed(bk1[0]);
      pa[4] <= $signed(so1.up[2]) * $signed(bk1[1]);
      pa[5] <= $signed(so1.up[1]) * $signed(bk1[2]);
      c1s.eye <= so1.eye;
      c1s.bk  <= bk1;
      v2[2] <= pa[0] - pa[1];
      v2[1] <= pa[2] - pa[3];
      v2[0] <= pa[4] - pa[5];
      c2s <= c1s;
    end
  end

  sd2_t             so2;
  logic [2:0][31:0] rt2;

  lavm_norm #(.FRAC(FRAC), .SIDE_T(sd2_t)) u_norm_right (
    .clk(clk), .en(en), .v_in(v2), .side_in(c2s), .u_out(rt2), .side_out(so2)
  );

  logic signed [63:0] pb [6];
  sd3_t c3s, c4s;
  logic [2:0][63:0] v3;

  always_ff @(posedge clk) begin
    if (en) begin
      pb[0] <= $signed(so2.bk[1]) * $signed(rt2[0]);
      pb[1] <= $signed(so2.bk[0]) * $signed(rt2[1]);
      pb[2] <= $signed(so2.bk[0]) * $signed(rt2[2]);
      pb[3] <= $signed(so2.bk[2]) * $signed(rt2[0]);
      pb[4] <= $signed(so2.bk[2]) * $signed(rt2[1]);
      pb[5] <= $signed(so2.bk[1]) * $signed(rt2[2]);
      c3s.eye <= so2.eye;
      c3s.bk  <= so2.bk;
      c3s.rt  <= rt2;
      v3[2] <= pb[0] - pb[1];
      v3[1] <= pb[2] - pb[3];
      v3[0] <= pb[4] - pb[5];
      c4s <= c3s;
    end
  end

  sd3_t             so3;
  logic [2:0][31:0] tu3;

  lavm_norm #(.FRAC(FRAC), .SIDE_T(sd3_t)) u_norm_up (
    .clk(clk), .en(en), .v_in(v3), .side_in(c4s), .u_out(tu3), .side_out(so3)
  );

  logic signed [63:0] pd [3][3];
  logic [2:0][2:0][31:0] ax;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pd[0][i] <= $signed(so3.rt[i]) * $signed(so3.eye[i]);
        pd[1][i] <= $signed(tu3[i]) * $signed(so3.eye[i]);
        pd[2][i] <= $signed(so3.bk[i]) * $signed(so3.eye[i]);
      end
      ax[2] <= so3.rt;
      ax[1] <= tu3;
      ax[0] <= so3.bk;
    end
  end

  logic [2:0][31:0] off;

  always_comb begin
    logic signed [63:0] s, r;
    for (int k = 0; k < 3; k++) begin
      s = -(pd[k][0] + pd[k][1] + pd[k][2]);
      r = (s + HALF) >>> FRAC;
      if (r > 64'sd2147483647)       off[2-k] = 32'h7fffffff;
      else if (r < -64'sd2147483648) off[2-k] = 32'h80000000;
      else                           off[2-k] = r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_data.right_x        <= ax[2][2];
      o_data.right_y        <= ax[2][1];
      o_data.right_z        <= ax[2][0];
      o_data.right_offset   <= off[2];
      o_data.true_up_x      <= ax[1][2];
      o_data.true_up_y      <= ax[1][1];
      o_data.true_up_z      <= ax[1][0];
      o_data.true_up_offset <= off[1];
      o_data.back_x         <= ax[0][2];
      o_data.back_y         <= ax[0][1];
      o_data.back_z         <= ax[0][0];
      o_data.back_offset    <= off[0];
    end
  end
endmodule
`default_nettype wire

// ===== design/look_at_view_matrix.sv =====
// Top level of the look-at view matrix setup engine.
// Usage:
//   Requests enter as queue writes: drive pose and push; a request is taken at
//   a clock edge with push high and full low. Results leave as queue reads:
//   while empty is low, result holds the oldest matrix rows; pop high at an
//   edge with empty low takes it. Requests and results match one to one, in
//   order.
//   One request per cycle is sustained while the pipeline does not stall: the
//   datapath is a single pipeline with a register per step of each square
//   root and divider.
//   The input stage feeds a short queue in front of the pipeline; the pipeline
//   advances as a whole and halts only when its last stage holds a result and
//   the output queue is full, so a stalled receiver fills the queues and then
//   raises full. Synchronous reset empties every queue and the pipeline.
`default_nettype none
module look_at_view_matrix #(
  parameter int FRACTION_BITS = lavm_pkg::FRAC_BITS
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  output logic                full,
  input  wire lavm_pkg::in_t  pose,
  input  wire logic           pop,
  output logic                empty,
  output lavm_pkg::out_t      result
);
  logic           fq_push, fq_full, fq_empty, fq_pop;
  lavm_pkg::fwd_t fq_wdata, fq_rdata;
  logic           o_push, o_full;
  lavm_pkg::out_t o_data;

  lavm_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .pose(pose),
    .q_push(fq_push), .q_full(fq_full), .q_data(fq_wdata)
  );

  lavm_fifo #(.T(lavm_pkg::fwd_t), .DEPTH(lavm_pkg::Q_DEPTH)) u_mid_q (
    .clk(clk), .rst(rst), .wr(fq_push), .wdata(fq_wdata), .full(fq_full),
    .rd(fq_pop), .rdata(fq_rdata), .empty(fq_empty)
  );

  lavm_back #(.FRAC(FRACTION_BITS)) u_back (
    .clk(clk), .rst(rst), .q_empty(fq_empty), .q_data(fq_rdata), .q_pop(fq_pop),
    .o_push(o_push), .o_full(o_full), .o_data(o_data)
  );

  lavm_fifo #(.T(lavm_pkg::out_t), .DEPTH(lavm_pkg::Q_DEPTH)) u_out_q (
    .clk(clk), .rst(rst), .wr(o_push), .wdata(o_data), .full(o_full),
    .rd(pop), .rdata(result), .empty(empty)
  );

  a_no_out_overflow: assert property (@(posedge clk) disable iff (rst)
    !(o_push && o_full)) else $error("output queue overflow");

  a_no_mid_underflow: assert property (@(posedge clk) disable iff (rst)
    !(fq_pop && fq_empty) || !fq_pop) else $error("mid queue underflow");

  a_front_handoff: assert property (@(posedge clk) disable iff (rst)
    fq_push |-> !fq_full) else $error("front hands off into full queue");
endmodule
`default_nettype wire
